// ===== design/bfa_pkg.sv =====
// Shared constants, word types and bit helpers for the bitmap frame allocator.
`default_nettype none

package bfa_pkg;

  localparam int unsigned NUM_BLOCKS = 32768;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned WORD_AW    = $clog2(MAP_WORDS);
  localparam int unsigned DELTA_W    = $clog2(WORD_BITS + 1);
  localparam int unsigned BLK_W      = 15;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

  localparam logic [CNT_W-1:0] RESET_TOTAL = 16'd32768;
  localparam logic [CNT_W-1:0] RESET_KEND  = 16'd256;
  localparam logic [CNT_W-1:0] RESET_COUNT =
    (RESET_TOTAL < CNT_W'(NUM_BLOCKS)) ? RESET_TOTAL : CNT_W'(NUM_BLOCKS);

  localparam logic [KIND_W-1:0] KIND_ALLOC          = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREE           = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FREE_REGION    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESERVE_REGION = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MARK_ALL       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFREE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEND  = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BLK_W-1:0]  start_block;
    logic [CNT_W-1:0]  block_count;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    block_index;
    logic [CNT_W-1:0]    used_count;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] eff_total;
    logic [CNT_W-1:0] kernel_end;
  } cfg_t;

  function automatic logic [DELTA_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
    logic [DELTA_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + DELTA_W'(w[i]);
    end
    return n;
  endfunction

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== design/bfa_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module bfa_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/bfa_ctrl.sv =====
// Command sequencer: decodes commands, sweeps and scans the bitmap RAM, keeps the used count.
`default_nettype none

module bfa_ctrl import bfa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  input  cfg_t cfg_i,
  output logic busy_o,
  output res_t res_o,
  output logic res_strobe_o
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RUN, S_FIN} state_e;
  typedef enum logic [1:0] {OP_SET, OP_CLR, OP_FIND} op_e;

  state_e               state_q;
  op_e                  op_q;
  logic [BLK_W-1:0]     lo_q;
  logic [BLK_W-1:0]     hm1_q;
  logic                 skip0_q;
  logic [WORD_AW-1:0]   iss_w_q;
  logic                 iss_done_q;
  logic                 rd_vld_q;
  logic [WORD_AW-1:0]   rd_w_q;
  logic [DELTA_W-1:0]   delta_q;
  logic                 delta_inc_q;
  logic                 delta_vld_q;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     count_d;
  logic [STATUS_W-1:0]  status_q;
  logic [BLK_W-1:0]     index_q;
  logic                 clr_resp_q;
  res_t                 res_q;
  logic                 res_strobe_q;

  // command decode
  logic [CNT_W-1:0]    start_ext;
  logic [CNT_W:0]      reg_sum;
  logic [CNT_W-1:0]    reg_end;
  logic                dec_go;
  logic                dec_all;
  op_e                 dec_op;
  logic [BLK_W-1:0]    dec_lo;
  logic [BLK_W-1:0]    dec_hm1;
  logic                dec_skip0;
  logic [STATUS_W-1:0] dec_status;

  assign start_ext = CNT_W'(cmd_i.start_block);
  assign reg_sum   = {1'b0, start_ext} + {1'b0, cmd_i.block_count};
  assign reg_end   = (reg_sum > {1'b0, cfg_i.eff_total}) ? cfg_i.eff_total
                                                         : reg_sum[CNT_W-1:0];

  always_comb begin
    dec_go     = 1'b0;
    dec_all    = 1'b0;
    dec_op     = OP_SET;
    dec_lo     = cmd_i.start_block;
    dec_hm1    = cmd_i.start_block;
    dec_skip0  = 1'b0;
    dec_status = ST_DONE;
    case (cmd_i.kind)
      KIND_ALLOC: begin
        dec_op  = OP_FIND;
        dec_lo  = '0;
        dec_hm1 = BLK_W'(cfg_i.eff_total - 1'b1);
        if (cfg_i.eff_total == '0) begin
          dec_status = ST_NOFREE;
        end else begin
          dec_go = 1'b1;
        end
      end
      KIND_FREE: begin
        dec_op = OP_CLR;
        if (start_ext < cfg_i.kernel_end) begin
          dec_status = ST_IGNORED;
        end else if (cmd_i.start_block != '0 && start_ext < cfg_i.eff_total) begin
          dec_go = 1'b1;
        end
      end
      KIND_FREE_REGION, KIND_RESERVE_REGION: begin
        dec_op    = (cmd_i.kind == KIND_FREE_REGION) ? OP_CLR : OP_SET;
        dec_skip0 = (cmd_i.kind == KIND_FREE_REGION);
        dec_hm1   = BLK_W'(reg_end - 1'b1);
        dec_go    = (start_ext < reg_end);
      end
      KIND_MARK_ALL: begin
        dec_all = 1'b1;
      end
      default: begin
        dec_go = 1'b0;
      end
    endcase
  end

  // word modify
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] sel;
  logic [WORD_BITS-1:0] onehot;
  logic [WORD_BITS-1:0] wnew;
  logic [DELTA_W-1:0]   flips;
  logic                 found;
  logic                 last;
  logic                 stop;
  logic                 ram_re;
  logic                 ram_we;
  logic [WORD_AW-1:0]   ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;

  assign lo_mask = (rd_w_q == lo_q[BLK_W-1:BIT_W]) ? (WORD_ONES << lo_q[BIT_W-1:0])
                                                   : WORD_ONES;
  assign hi_mask = (rd_w_q == hm1_q[BLK_W-1:BIT_W])
                   ? (WORD_ONES >> (BIT_W'(WORD_BITS - 1) - hm1_q[BIT_W-1:0]))
                   : WORD_ONES;

  always_comb begin
    mask = lo_mask & hi_mask;
    if (skip0_q && rd_w_q == '0) begin
      mask[0] = 1'b0;
    end
  end

  assign sel    = mask & ~ram_rdata;
  assign found  = |sel;
  assign onehot = sel & (~sel + 1'b1);

  always_comb begin
    case (op_q)
      OP_SET: begin
        wnew  = ram_rdata | mask;
        flips = popcount(mask & ~ram_rdata);
      end
      OP_CLR: begin
        wnew  = ram_rdata & ~mask;
        flips = popcount(mask & ram_rdata);
      end
      OP_FIND: begin
        wnew  = ram_rdata | onehot;
        flips = DELTA_W'(found);
      end
      default: begin
        wnew  = ram_rdata;
        flips = '0;
      end
    endcase
  end

  assign last   = (rd_w_q == hm1_q[BLK_W-1:BIT_W]) || (op_q == OP_FIND && found);
  assign stop   = (state_q == S_RUN) && rd_vld_q && last;
  assign ram_re = (state_q == S_RUN) && !iss_done_q && !stop;
  assign ram_we = (state_q == S_CLEAR) ||
                  ((state_q == S_RUN) && rd_vld_q && (op_q != OP_FIND || found));
  assign ram_waddr = (state_q == S_CLEAR) ? iss_w_q : rd_w_q;
  assign ram_wdata = (state_q == S_CLEAR) ? WORD_ONES : wnew;

  // saturating count update
  logic [CNT_W:0] inc_sum;

  assign inc_sum = {1'b0, count_q} + (CNT_W + 1)'(delta_q);

  always_comb begin
    count_d = count_q;
    if (delta_vld_q) begin
      if (delta_inc_q) begin
        count_d = inc_sum[CNT_W] ? '1 : inc_sum[CNT_W-1:0];
      end else begin
        count_d = (count_q < CNT_W'(delta_q)) ? '0 : count_q - CNT_W'(delta_q);
      end
    end
  end

  bfa_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (iss_w_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      iss_w_q      <= '0;
      iss_done_q   <= 1'b0;
      rd_vld_q     <= 1'b0;
      delta_vld_q  <= 1'b0;
      count_q      <= RESET_COUNT;
      clr_resp_q   <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      res_strobe_q <= 1'b0;
      delta_vld_q  <= 1'b0;
      count_q      <= count_d;
      case (state_q)
        S_CLEAR: begin
          iss_w_q <= iss_w_q + 1'b1;
          if (iss_w_q == WORD_AW'(MAP_WORDS - 1)) begin
            state_q    <= clr_resp_q ? S_FIN : S_IDLE;
            clr_resp_q <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            status_q   <= dec_status;
            index_q    <= '0;
            op_q       <= dec_op;
            lo_q       <= dec_lo;
            hm1_q      <= dec_hm1;
            skip0_q    <= dec_skip0;
            iss_w_q    <= dec_lo[BLK_W-1:BIT_W];
            iss_done_q <= 1'b0;
            rd_vld_q   <= 1'b0;
            if (dec_all) begin
              count_q    <= cfg_i.eff_total;
              iss_w_q    <= '0;
              clr_resp_q <= 1'b1;
              state_q    <= S_CLEAR;
            end else if (dec_go) begin
              state_q <= S_RUN;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_RUN: begin
          delta_vld_q <= rd_vld_q;
          delta_q     <= flips;
          delta_inc_q <= (op_q != OP_CLR);
          rd_vld_q    <= ram_re;
          if (ram_re) begin
            iss_w_q    <= iss_w_q + 1'b1;
            iss_done_q <= (iss_w_q == hm1_q[BLK_W-1:BIT_W]);
            rd_w_q     <= iss_w_q;
          end
          if (stop) begin
            state_q <= S_FIN;
            if (op_q == OP_FIND) begin
              if (found) begin
                index_q <= {rd_w_q, lowest_set(sel)};
              end else begin
                status_q <= ST_NOFREE;
              end
            end
          end
        end
        S_FIN: begin
          res_q.status      <= status_q;
          res_q.block_index <= index_q;
          res_q.used_count  <= count_d;
          res_strobe_q      <= 1'b1;
          state_q           <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_o        = res_q;
  assign res_strobe_o = res_strobe_q;

endmodule

`default_nettype wire

// ===== design/bitmap_frame_allocator.sv =====
// Bitmap frame allocator top level: configuration registers and command sequencer.
// A command that touches bitmap words reads, modifies and writes each word in turn before
// its result is strobed; a command touching no word strobes directly, mark-all-used after a full sweep.
// Throughput is one bitmap word per cycle, set by the single RAM read port;
// busy drops in the cycle the result strobe is shown.
// After reset a sweep over all 1024 bitmap words marks every block used; busy stays high meanwhile.
`default_nettype none

module bitmap_frame_allocator import bfa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  cmd_t                 cmd_i,
  output res_t                 res_o,
  output logic                 res_strobe_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  logic [CNT_W-1:0] total_q;
  logic [CNT_W-1:0] kend_q;
  cfg_t             cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= RESET_TOTAL;
      kend_q  <= RESET_KEND;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TOTAL: total_q <= cfg_data_i;
        CFG_KEND:  kend_q  <= cfg_data_i;
        default: begin
          total_q <= total_q;
        end
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign cfg.eff_total = (total_q < CNT_W'(NUM_BLOCKS)) ? total_q : CNT_W'(NUM_BLOCKS);
  assign cfg.kernel_end = kend_q;

  bfa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .cmd_i        (cmd_i),
    .cfg_i        (cfg),
    .busy_o       (busy),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o)
  );

endmodule

`default_nettype wire
